// ===== design/m2m_pkg.sv =====
// Shared types and constants for the memory-to-memory instruction executor.
// Depends on nothing; every other file refers to it by scoped names.
package m2m_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 7;
  localparam int unsigned LINE_W        = 16;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned MEM_WORDS_DEF = 128;
  localparam int unsigned DIV_STEPS     = 32;

  // Instruction codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_MUL     = 4'd1,
    OP_SUB     = 4'd2,
    OP_DIV     = 4'd3,
    OP_COPY    = 4'd4,
    OP_LOADI   = 4'd5,
    OP_JUMP    = 4'd6,
    OP_JZ      = 4'd7,
    OP_LESS    = 4'd8,
    OP_GREATER = 4'd9,
    OP_EQUAL   = 4'd10,
    OP_PRINT   = 4'd11
  } opcode_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic exec;
    logic div_start;
    logic mem_write;
    logic out_load;
    logic clear;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic div_nz;
    logic div_done;
    logic out_free;
    logic clear_last;
  } dpath_sts_t;

endpackage

// ===== design/m2m_in_if.sv =====
// Instruction channel: valid/ready handshake plus one decoded instruction.
// Depends on m2m_pkg for field widths.
interface m2m_in_if;
  logic                               valid;
  logic                               ready;
  logic [m2m_pkg::OP_W-1:0]           opcode;
  logic [m2m_pkg::ADDR_W-1:0]         dest_addr;
  logic [m2m_pkg::ADDR_W-1:0]         src_a_addr;
  logic [m2m_pkg::ADDR_W-1:0]         src_b_addr;
  logic signed [m2m_pkg::DATA_W-1:0]  immediate;
  logic [m2m_pkg::LINE_W-1:0]         target_line;

  modport source (
    output valid, opcode, dest_addr, src_a_addr, src_b_addr, immediate, target_line,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_addr, src_a_addr, src_b_addr, immediate, target_line,
    output ready
  );
endinterface

// ===== design/m2m_out_if.sv =====
// Result channel: valid/ready handshake plus one result per instruction.
// Depends on m2m_pkg for field widths.
interface m2m_out_if;
  logic                               valid;
  logic                               ready;
  logic                               print_valid;
  logic signed [m2m_pkg::DATA_W-1:0]  print_value;
  logic                               jump_taken;
  logic [m2m_pkg::LINE_W-1:0]         jump_line;
  logic                               div_by_zero;

  modport source (
    output valid, print_valid, print_value, jump_taken, jump_line, div_by_zero,
    input  ready
  );
  modport sink (
    input  valid, print_valid, print_value, jump_taken, jump_line, div_by_zero,
    output ready
  );
endinterface

// ===== design/m2m_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// Depends on m2m_pkg for the data width and step count.
module m2m_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [m2m_pkg::DATA_W-1:0]   dividend_i,
  input  logic [m2m_pkg::DATA_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [m2m_pkg::DATA_W-1:0]   quot_o
);

  localparam int unsigned DW   = m2m_pkg::DATA_W;
  localparam int unsigned CntW = $clog2(m2m_pkg::DIV_STEPS);

  logic [DW:0]     rem_q, rem_d, rem_sh;
  logic [DW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, fin_q, neg_q;
  logic            ge;
  logic            na, nb;

  assign na = dividend_i[DW-1];
  assign nb = divisor_i[DW-1];

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_d  = {quo_q[DW-2:0], ge};
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(m2m_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // operands work on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= na ? (DW'(0) - dividend_i) : dividend_i;
      dvs_q <= nb ? (DW'(0) - divisor_i) : divisor_i;
      neg_q <= na ^ nb;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = fin_q;
  assign quot_o = neg_q ? (DW'(0) - quo_q) : quo_q;

endmodule

// ===== design/m2m_dpath.sv =====
// Datapath: data memory, operand registers, ALU, divider and result register.
// Depends on m2m_pkg, m2m_in_if, m2m_out_if and m2m_div.
module m2m_dpath #(
  parameter int unsigned MEM_WORDS = m2m_pkg::MEM_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  m2m_pkg::ctrl_cmd_t    cmd_i,
  output m2m_pkg::dpath_sts_t   sts_o,
  m2m_in_if.sink                inst_i,
  m2m_out_if.source             res_o
);

  localparam int unsigned DW = m2m_pkg::DATA_W;
  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned LW = m2m_pkg::LINE_W;

  typedef struct packed {
    logic          print_valid;
    logic [DW-1:0] print_value;
    logic          jump_taken;
    logic [LW-1:0] jump_line;
    logic          div_by_zero;
  } result_t;

  logic [DW-1:0]   mem_q [MEM_WORDS];

  logic [m2m_pkg::OP_W-1:0] op_q;
  logic [DW-1:0]   imm_q;
  logic [LW-1:0]   line_q;
  logic [AW-1:0]   dest_idx_q;
  logic            dest_ok_q;
  logic [DW-1:0]   rd_a_q, rd_b_q;
  logic            a_ok_q, b_ok_q;
  logic [DW-1:0]   a_val, b_val;

  logic [DW-1:0]   wr_data_q;
  logic            wr_en_q;
  result_t         res_q, res_d;
  logic [DW-1:0]   alu;
  logic            wr_req;

  logic [AW-1:0]   clr_q;
  logic            out_valid_q;
  result_t         out_q;

  logic [m2m_pkg::ADDR_W-1:0] addr_a;
  logic [31:0]     ext_a, ext_b, ext_d;
  logic            ok_a, ok_b, ok_d;
  logic [AW-1:0]   idx_a, idx_b, idx_d;
  m2m_pkg::opcode_e in_op, op;
  logic            div_done;
  logic [DW-1:0]   div_quot;

  // read address select and range checks
  assign in_op  = m2m_pkg::opcode_e'(inst_i.opcode);
  assign addr_a = (in_op == m2m_pkg::OP_JZ || in_op == m2m_pkg::OP_PRINT) ?
                  inst_i.dest_addr : inst_i.src_a_addr;
  assign ext_a  = 32'(addr_a);
  assign ext_b  = 32'(inst_i.src_b_addr);
  assign ext_d  = 32'(inst_i.dest_addr);
  assign ok_a   = ext_a < 32'(MEM_WORDS);
  assign ok_b   = ext_b < 32'(MEM_WORDS);
  assign ok_d   = ext_d < 32'(MEM_WORDS);
  assign idx_a  = ok_a ? ext_a[AW-1:0] : '0;
  assign idx_b  = ok_b ? ext_b[AW-1:0] : '0;
  assign idx_d  = ok_d ? ext_d[AW-1:0] : '0;

  // memory: two registered reads at capture, one write port shared with clearing
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.mem_write && wr_en_q) begin
      mem_q[dest_idx_q] <= wr_data_q;
    end
    if (cmd_i.capture) begin
      rd_a_q <= mem_q[idx_a];
      rd_b_q <= mem_q[idx_b];
    end
  end

  // clearing pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // instruction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= inst_i.opcode;
      imm_q      <= inst_i.immediate;
      line_q     <= inst_i.target_line;
      dest_idx_q <= idx_d;
      dest_ok_q  <= ok_d;
      a_ok_q     <= ok_a;
      b_ok_q     <= ok_b;
    end
  end

  assign a_val = a_ok_q ? rd_a_q : '0;
  assign b_val = b_ok_q ? rd_b_q : '0;
  assign op    = m2m_pkg::opcode_e'(op_q);

  // ALU and result fields
  always_comb begin
    alu    = '0;
    wr_req = 1'b0;
    res_d  = '0;
    case (op)
      m2m_pkg::OP_ADD: begin
        alu = a_val + b_val; wr_req = 1'b1;
      end
      m2m_pkg::OP_MUL: begin
        alu = a_val * b_val; wr_req = 1'b1;
      end
      m2m_pkg::OP_SUB: begin
        alu = a_val - b_val; wr_req = 1'b1;
      end
      m2m_pkg::OP_DIV: begin
        wr_req            = (b_val != '0);
        res_d.div_by_zero = (b_val == '0);
      end
      m2m_pkg::OP_COPY: begin
        alu = a_val; wr_req = 1'b1;
      end
      m2m_pkg::OP_LOADI: begin
        alu = imm_q; wr_req = 1'b1;
      end
      m2m_pkg::OP_JUMP: begin
        res_d.jump_taken = 1'b1;
        res_d.jump_line  = line_q;
      end
      m2m_pkg::OP_JZ: begin
        if (a_val == '0) begin
          res_d.jump_taken = 1'b1;
          res_d.jump_line  = line_q;
        end
      end
      m2m_pkg::OP_LESS: begin
        alu = DW'($signed(a_val) < $signed(b_val)); wr_req = 1'b1;
      end
      m2m_pkg::OP_GREATER: begin
        alu = DW'($signed(a_val) > $signed(b_val)); wr_req = 1'b1;
      end
      m2m_pkg::OP_EQUAL: begin
        alu = DW'(a_val == b_val); wr_req = 1'b1;
      end
      m2m_pkg::OP_PRINT: begin
        res_d.print_valid = 1'b1;
        res_d.print_value = a_val;
      end
      default: begin
      end
    endcase
  end

  m2m_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_val),
    .divisor_i  (b_val),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // write-back register: ALU result after execute, quotient when division ends
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      wr_data_q <= alu;
      wr_en_q   <= wr_req && dest_ok_q;
      res_q     <= res_d;
    end else if (div_done) begin
      wr_data_q <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.print_valid = out_q.print_valid;
  assign res_o.print_value = out_q.print_value;
  assign res_o.jump_taken  = out_q.jump_taken;
  assign res_o.jump_line   = out_q.jump_line;
  assign res_o.div_by_zero = out_q.div_by_zero;
  assign inst_i.ready      = cmd_i.in_ready;

  // status
  assign sts_o.in_valid   = inst_i.valid;
  assign sts_o.div_nz     = (op == m2m_pkg::OP_DIV) && (b_val != '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || res_o.ready;
  assign sts_o.clear_last = (clr_q == AW'(MEM_WORDS - 1));

endmodule

// ===== design/m2m_ctrl.sv =====
// Controller state machine: clearing pass, capture, execute, divide wait,
// write-back and result hand-off. Depends on m2m_pkg.
module m2m_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  m2m_pkg::dpath_sts_t   sts_i,
  output m2m_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = sts_i.in_valid;
        if (sts_i.in_valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.div_nz) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.mem_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/memory_to_memory_instruction_executor_core.sv =====
// Top level of the memory-to-memory instruction executor.
// Depends on m2m_pkg, m2m_in_if, m2m_out_if, m2m_ctrl and m2m_dpath.

// Executes one decoded three-address instruction per transfer on inst_i against
// a data memory of MEM_WORDS signed 32-bit words and returns exactly one result
// transfer on res_o. After reset it zeroes the memory, one word per cycle,
// before it takes the first instruction. After an instruction is accepted the
// controller steps through execute, write-back and done states, and the result
// register loads in the done state. A divide with a nonzero divisor also waits
// in a divide state between execute and write-back until the divider finishes.
// The result register only loads once the previous result has left or leaves
// in that cycle, so a stalled sink holds the block in the done state. The next
// instruction is accepted as soon as the previous result is in the output
// register, even if the sink has not taken it yet. Addresses at or above
// MEM_WORDS read as zero and are never written. A divide by zero leaves the
// destination untouched and flags div_by_zero.
module memory_to_memory_instruction_executor_core #(
  parameter int unsigned MEM_WORDS = m2m_pkg::MEM_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  m2m_in_if.sink     inst_i,
  m2m_out_if.source  res_o
);

  m2m_pkg::ctrl_cmd_t  cmd;
  m2m_pkg::dpath_sts_t sts;

  m2m_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  m2m_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .inst_i (inst_i),
    .res_o  (res_o)
  );

  // one instruction at a time: no accept right after an accept
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inst_i.valid && inst_i.ready) |=> !inst_i.ready)
    else $error("instruction accepted while previous one still executing");

  // divide-by-zero never comes with a print or a jump
  a_dz_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.div_by_zero) |-> !(res_o.print_valid || res_o.jump_taken))
    else $error("div_by_zero result also reports print or jump");

  // jump line is zero unless a jump was taken
  a_jump_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.jump_taken) |-> (res_o.jump_line == '0))
    else $error("jump_line nonzero without a taken jump");

  // print value is zero unless printing
  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.print_valid) |-> (res_o.print_value == '0))
    else $error("print_value nonzero without print");

endmodule

// ===== bench/tb_memory_to_memory_instruction_executor_core.sv =====
// Testbench for memory_to_memory_instruction_executor_core: a local model of the
// data memory predicts every result, which is checked under idle and stall phases.
// Depends on m2m_pkg, m2m_in_if, m2m_out_if and the core itself.
module tb_memory_to_memory_instruction_executor_core;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned TIMEOUT      = 8_000_000;
  localparam int unsigned BURST_ITEMS  = 285;
  localparam int unsigned OP_W         = m2m_pkg::OP_W;
  localparam int unsigned ADDR_W       = m2m_pkg::ADDR_W;
  localparam int unsigned DATA_W       = m2m_pkg::DATA_W;
  localparam int unsigned LINE_W       = m2m_pkg::LINE_W;
  localparam int unsigned ADDR_TOP     = 2**ADDR_W - 1;
  localparam int unsigned HOT_TOP      = 7;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_a_addr;
    logic [ADDR_W-1:0] src_b_addr;
    logic [DATA_W-1:0] immediate;
    logic [LINE_W-1:0] target_line;
  } inst_t;

  typedef struct packed {
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              jump_taken;
    logic [LINE_W-1:0] jump_line;
    logic              div_by_zero;
  } outcome_t;

  logic clk;
  logic rst_n;

  m2m_in_if  inst_if ();
  m2m_out_if res_if ();

  memory_to_memory_instruction_executor_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .inst_i (inst_if),
    .res_o  (res_if)
  );

  // Shadow copy of the data memory; all words are zero after reset
  logic [DATA_W-1:0] shadow_mem [m2m_pkg::MEM_WORDS_DEF] = '{default: '0};
  outcome_t          pending_q [$];
  int unsigned       error_count   = 0;
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_stall_pct = 0;

  // Clock
  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Executes one instruction on the shadow memory and returns its outcome
  function automatic outcome_t execute_shadow(inst_t inst);
    outcome_t          res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] quo;
    res = '0;
    a = shadow_mem[inst.src_a_addr];
    b = shadow_mem[inst.src_b_addr];
    case (inst.opcode)
      m2m_pkg::OP_ADD:   shadow_mem[inst.dest_addr] = a + b;
      m2m_pkg::OP_MUL:   shadow_mem[inst.dest_addr] = a * b;
      m2m_pkg::OP_SUB:   shadow_mem[inst.dest_addr] = a - b;
      m2m_pkg::OP_DIV: begin
        if (b == '0) begin
          res.div_by_zero = 1'b1;
        end else begin
          // magnitudes divide unsigned; min / -1 wraps back to min
          mag_a = a[DATA_W-1] ? (~a + 1'b1) : a;
          mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
          quo   = mag_a / mag_b;
          shadow_mem[inst.dest_addr] = (a[DATA_W-1] != b[DATA_W-1]) ? (~quo + 1'b1) : quo;
        end
      end
      m2m_pkg::OP_COPY:  shadow_mem[inst.dest_addr] = a;
      m2m_pkg::OP_LOADI: shadow_mem[inst.dest_addr] = inst.immediate;
      m2m_pkg::OP_JUMP: begin
        res.jump_taken = 1'b1;
        res.jump_line  = inst.target_line;
      end
      m2m_pkg::OP_JZ: begin
        if (shadow_mem[inst.dest_addr] == '0) begin
          res.jump_taken = 1'b1;
          res.jump_line  = inst.target_line;
        end
      end
      m2m_pkg::OP_LESS:    shadow_mem[inst.dest_addr] = ($signed(a) < $signed(b)) ? 1 : 0;
      m2m_pkg::OP_GREATER: shadow_mem[inst.dest_addr] = ($signed(a) > $signed(b)) ? 1 : 0;
      m2m_pkg::OP_EQUAL:   shadow_mem[inst.dest_addr] = (a == b) ? 1 : 0;
      m2m_pkg::OP_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = shadow_mem[inst.dest_addr];
      end
      default: ;  // spare codes: no effect, all-zero result
    endcase
    return res;
  endfunction

  // One instruction transfer, then a random idle gap on the source side
  task automatic send_inst(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dst,
                           input logic [ADDR_W-1:0] sa, input logic [ADDR_W-1:0] sb,
                           input logic [DATA_W-1:0] imm, input logic [LINE_W-1:0] line);
    inst_t       inst;
    int unsigned gap;
    inst = '{op, dst, sa, sb, imm, line};
    inst_if.valid       <= 1'b1;
    inst_if.opcode      <= op;
    inst_if.dest_addr   <= dst;
    inst_if.src_a_addr  <= sa;
    inst_if.src_b_addr  <= sb;
    inst_if.immediate   <= imm;
    inst_if.target_line <= line;
    @(posedge clk);
    while (!inst_if.ready) @(posedge clk);
    pending_q.push_back(execute_shadow(inst));
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      inst_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly a few hot words so results feed later instructions
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(3) != 0) return ADDR_W'($urandom_range(HOT_TOP));
    return ADDR_W'($urandom_range(ADDR_TOP));
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5:       return DATA_W'($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Random program fragment; a few spare codes mixed in as noise
  task automatic random_burst(input int unsigned count);
    logic [OP_W-1:0] op;
    repeat (count) begin
      if ($urandom_range(99) < 6) op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      else if ($urandom_range(99) < 15) op = m2m_pkg::OP_LOADI;
      else op = OP_W'($urandom_range(m2m_pkg::OP_PRINT, m2m_pkg::OP_ADD));
      send_inst(op, pick_addr(), pick_addr(), pick_addr(), pick_word(),
                LINE_W'($urandom));
    end
  endtask

  task automatic set_pressure(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   <= src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // Field extremes, wrap cases, divide corners, every opcode and the spare codes
  task automatic test_directed_corners();
    set_pressure(0, 0);
    send_inst(m2m_pkg::OP_LOADI, 0, 0, 0, WORD_MAX, 0);
    send_inst(m2m_pkg::OP_LOADI, 1, 0, 0, WORD_MIN, 0);
    send_inst(m2m_pkg::OP_LOADI, 2, 0, 0, '1, 0);
    send_inst(m2m_pkg::OP_LOADI, ADDR_W'(ADDR_TOP), 0, 0, 32'h5A5A_A5A5, 0);
    send_inst(m2m_pkg::OP_ADD, 4, 0, 0, '0, 0);
    send_inst(m2m_pkg::OP_SUB, 5, 1, 0, '0, 0);
    send_inst(m2m_pkg::OP_MUL, 6, 0, 0, '0, 0);
    send_inst(m2m_pkg::OP_DIV, 7, 1, 2, '0, 0);
    // divide by zero must keep the min value just written
    send_inst(m2m_pkg::OP_DIV, 7, 0, 3, '0, 0);
    send_inst(m2m_pkg::OP_LOADI, 9, 0, 0, -7, 0);
    send_inst(m2m_pkg::OP_LOADI, 10, 0, 0, 2, 0);
    send_inst(m2m_pkg::OP_DIV, 11, 9, 10, '0, 0);
    send_inst(m2m_pkg::OP_COPY, 13, ADDR_W'(ADDR_TOP), 0, '0, 0);
    send_inst(m2m_pkg::OP_LESS, 14, 1, 0, '0, 0);
    send_inst(m2m_pkg::OP_GREATER, 15, 1, 0, '0, 0);
    send_inst(m2m_pkg::OP_EQUAL, 16, 2, 2, '0, 0);
    send_inst(m2m_pkg::OP_PRINT, ADDR_W'(ADDR_TOP), 0, 0, '0, 0);
    send_inst(m2m_pkg::OP_PRINT, 7, 0, 0, '0, 0);
    send_inst(m2m_pkg::OP_JUMP, 0, 0, 0, '0, '1);
    send_inst(m2m_pkg::OP_JZ, 3, 0, 0, '0, '0);
    send_inst(m2m_pkg::OP_JZ, 0, 0, 0, '0, 16'h1234);
    for (int unsigned code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
      send_inst(OP_W'(code), '1, '1, '1, '1, '1);
    end
  endtask

  task automatic test_back_to_back();
    set_pressure(0, 0);
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_source_gaps();
    set_pressure(59, 0);
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_sink_backpressure();
    set_pressure(0, 59);
    random_burst(BURST_ITEMS);
  endtask

  task automatic test_mixed_pressure();
    set_pressure(29, 29);
    random_burst(BURST_ITEMS);
  endtask

  // Result sink: random stalls at the current pressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        exp_res = pending_q.pop_front();
        check_field("print_valid", exp_res.print_valid, res_if.print_valid);
        check_field("print_value", exp_res.print_value, res_if.print_value);
        check_field("jump_taken", exp_res.jump_taken, res_if.jump_taken);
        check_field("jump_line", exp_res.jump_line, res_if.jump_line);
        check_field("div_by_zero", exp_res.div_by_zero, res_if.div_by_zero);
      end
    end
  end

  // Main sequence
  initial begin
    rst_n               <= 1'b0;
    inst_if.valid       <= 1'b0;
    inst_if.opcode      <= '0;
    inst_if.dest_addr   <= '0;
    inst_if.src_a_addr  <= '0;
    inst_if.src_b_addr  <= '0;
    inst_if.immediate   <= '0;
    inst_if.target_line <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_back_to_back();
    test_source_gaps();
    test_sink_backpressure();
    test_mixed_pressure();
    inst_if.valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
